>>> hw/rtl/nsfc_pkg.sv
package nsfc_pkg;

  localparam logic [7:0] MAX_SENTENCE_BYTES = 8'd128;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    ST_INCOMPLETE = 3'd0,
    ST_IGNORED    = 3'd1,
    ST_OVERRUN    = 3'd2,
    ST_BAD        = 3'd3,
    ST_GOOD       = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
    logic [15:0] overrun_total;
    logic [15:0] checksum_error_total;
  } result_t;

endpackage

>>> hw/rtl/nsfc_if.sv
interface nsfc_in_if;
  import nsfc_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsfc_out_if;
  import nsfc_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  computed_checksum;
  logic [7:0]  received_checksum;
  logic [15:0] overrun_total;
  logic [15:0] checksum_error_total;

  modport source (
    output valid, output status, output computed_checksum, output received_checksum,
    output overrun_total, output checksum_error_total, input ready
  );
  modport sink (
    input valid, input status, input computed_checksum, input received_checksum,
    input overrun_total, input checksum_error_total, output ready
  );
endinterface

>>> hw/rtl/nmea_sentence_framer_checksum.sv
// Channel   Role    Payload
// din       sink    rx_byte
// dout      source  status, computed_checksum, received_checksum,
//                   overrun_total, checksum_error_total
//
// Every byte beat gives exactly one result beat, through the byte register and then the result register.
// A byte register feeds the framing logic, which updates the sentence state and
// loads the result register together, so one beat per cycle is sustained while dout is ready.
// Reset clears the sentence state, both counters and both valid flags.
// A stalled result holds its beat; one more byte is taken before din stalls.
module nmea_sentence_framer_checksum
  import nsfc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  nsfc_in_if.sink   din,
  nsfc_out_if.source dout
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       out_valid;
  result_t    out_data;
  logic       advance;
  result_t    step_result;

  assign advance  = byte_valid && (!out_valid || dout.ready);
  assign din.ready = !byte_valid || advance;

  nsfc_frame_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (byte_data),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      byte_data <= din.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

  assign dout.valid                = out_valid;
  assign dout.status               = out_data.status;
  assign dout.computed_checksum    = out_data.computed_checksum;
  assign dout.received_checksum    = out_data.received_checksum;
  assign dout.overrun_total        = out_data.overrun_total;
  assign dout.checksum_error_total = out_data.checksum_error_total;

endmodule

>>> hw/rtl/nsfc_frame_ctrl.sv
module nsfc_frame_ctrl
  import nsfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output result_t    result
);

  typedef struct packed {
    logic [7:0] xor_sum;
    logic       star_seen;
    logic [7:0] hex_value;
    logic       hex_stopped;
    logic       zero_seen;
  } check_t;

  localparam check_t CHECK_CLEAR = '0;

  logic        in_sentence;
  logic        cr_pending;
  logic [7:0]  byte_count;
  check_t      check;
  logic [15:0] overrun_count;
  logic [15:0] checksum_error_count;

  logic        in_sentence_next;
  logic        cr_pending_next;
  logic [7:0]  byte_count_next;
  check_t      check_next;
  logic [15:0] overrun_count_next;
  logic [15:0] checksum_error_count_next;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic check_t feed(input check_t s, input logic [7:0] b);
    check_t     r;
    logic [4:0] d;
    r = s;
    d = hex_digit(b);
    if (!(s.zero_seen || s.hex_stopped)) begin
      if (s.star_seen) begin
        if (!d[4]) begin
          r.hex_stopped = 1'b1;
        end else begin
          r.hex_value = {s.hex_value[3:0], d[3:0]};
        end
      end else if (b == CH_NUL) begin
        r.zero_seen = 1'b1;
      end else if (b == CH_STAR) begin
        r.star_seen = 1'b1;
      end else begin
        r.xor_sum = s.xor_sum ^ b;
      end
    end
    return r;
  endfunction

  always_comb begin
    logic opening;
    logic good;
    opening                   = !in_sentence && (rx_byte == CH_DOLLAR);
    in_sentence_next          = in_sentence;
    cr_pending_next           = cr_pending;
    byte_count_next           = byte_count;
    check_next                = check;
    overrun_count_next        = overrun_count;
    checksum_error_count_next = checksum_error_count;
    good                      = 1'b0;
    result                    = '0;
    result.status             = ST_INCOMPLETE;

    if (opening) begin
      in_sentence_next = 1'b1;
      cr_pending_next  = 1'b0;
      byte_count_next  = '0;
      check_next       = CHECK_CLEAR;
    end

    if (!in_sentence_next) begin
      result.status = ST_IGNORED;
    end else if (byte_count_next >= MAX_SENTENCE_BYTES) begin
      overrun_count_next = overrun_count + 16'd1;
      in_sentence_next   = 1'b0;
      cr_pending_next    = 1'b0;
      byte_count_next    = '0;
      check_next         = CHECK_CLEAR;
      result.status      = ST_OVERRUN;
    end else begin
      byte_count_next = byte_count_next + 8'd1;
      if (opening) begin
        cr_pending_next = 1'b0;
      end else if (!cr_pending && rx_byte == CH_CR) begin
        cr_pending_next = 1'b1;
      end else if (cr_pending && rx_byte != CH_LF) begin
        cr_pending_next = 1'b0;
        check_next      = feed(feed(check, CH_CR), rx_byte);
      end else if (cr_pending) begin
        good = check.star_seen && !check.zero_seen && (check.xor_sum == check.hex_value);
        result.computed_checksum = check.xor_sum;
        result.received_checksum = check.hex_value;
        if (good) begin
          result.status = ST_GOOD;
        end else begin
          result.status             = ST_BAD;
          checksum_error_count_next = checksum_error_count + 16'd1;
        end
        in_sentence_next = 1'b0;
        cr_pending_next  = 1'b0;
        byte_count_next  = '0;
        check_next       = CHECK_CLEAR;
      end else begin
        check_next = feed(check, rx_byte);
      end
      if (result.status == ST_INCOMPLETE) begin
        result.computed_checksum = check_next.xor_sum;
        result.received_checksum = check_next.hex_value;
      end
    end

    result.overrun_total        = overrun_count_next;
    result.checksum_error_total = checksum_error_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence          <= 1'b0;
      cr_pending           <= 1'b0;
      byte_count           <= '0;
      check                <= CHECK_CLEAR;
      overrun_count        <= '0;
      checksum_error_count <= '0;
    end else if (step) begin
      in_sentence          <= in_sentence_next;
      cr_pending           <= cr_pending_next;
      byte_count           <= byte_count_next;
      check                <= check_next;
      overrun_count        <= overrun_count_next;
      checksum_error_count <= checksum_error_count_next;
    end
  end

endmodule

>>> hw/rtl/nsfc_checker.sv
module nsfc_checker
  import nsfc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        dout_valid,
  input logic        dout_ready,
  input logic [2:0]  status,
  input logic [7:0]  computed_checksum,
  input logic [7:0]  received_checksum,
  input logic [15:0] overrun_total,
  input logic [15:0] checksum_error_total
);

  logic        beat;
  logic        seen;
  logic [15:0] last_overrun;
  logic [15:0] last_error;

  assign beat = dout_valid && dout_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (beat) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      last_overrun <= overrun_total;
      last_error   <= checksum_error_total;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dout_valid && !dout_ready |=> dout_valid && $stable(status) &&
      $stable(computed_checksum) && $stable(received_checksum))
    else $error("Result beat changed while stalled.");

  a_dropped_zero: assert property (@(posedge clk) disable iff (rst)
    beat && (status == ST_IGNORED || status == ST_OVERRUN) |->
      computed_checksum == 8'd0 && received_checksum == 8'd0)
    else $error("Dropped byte carried nonzero checksums.");

  a_overrun_step: assert property (@(posedge clk) disable iff (rst)
    beat && seen |->
      overrun_total == last_overrun + 16'((status == ST_OVERRUN) ? 1 : 0))
    else $error("Overrun total moved without an overrun beat.");

  a_error_step: assert property (@(posedge clk) disable iff (rst)
    beat && seen |->
      checksum_error_total == last_error + 16'((status == ST_BAD) ? 1 : 0))
    else $error("Checksum error total moved without a bad sentence.");

endmodule

bind nmea_sentence_framer_checksum nsfc_checker u_nsfc_checker (
  .clk                  (clk),
  .rst                  (rst),
  .dout_valid           (dout.valid),
  .dout_ready           (dout.ready),
  .status               (dout.status),
  .computed_checksum    (dout.computed_checksum),
  .received_checksum    (dout.received_checksum),
  .overrun_total        (dout.overrun_total),
  .checksum_error_total (dout.checksum_error_total)
);
